@@ rtl/huffman_code_bit_packer_top_macros.svh @@
// Assertion macros shared by the packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// The antecedent must imply the consequent in the same cycle.
`define HCBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent must imply the consequent in the next cycle.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 31;
  localparam int SYM_W        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CODE_W       = 31;
  localparam int LEN_W        = 5;
  localparam int ENTRY_W      = CODE_W + LEN_W;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Requests from the sequencer to the packer.
  typedef struct packed {
    logic shift;
    logic bit_val;
    logic end_item;
    logic flush;
  } pk_cmd_t;

  typedef struct packed {
    logic hold;
    logic empty;
  } pk_stat_t;

endpackage

@@ rtl/hcbp_table.sv @@
module hcbp_table
  import hcbp_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [SYM_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [SYM_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/hcbp_packer.sv @@
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pk_cmd_t  cmd,
  output pk_stat_t stat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  logic [7:0] pend_bits, pend_bits_next;
  logic [3:0] pend_cnt, pend_cnt_next;
  logic [7:0] held, held_next;
  logic       held_valid, held_valid_next;
  logic       obuf_valid;
  out_t       obuf;
  logic       can_push;
  logic       push;
  out_t       push_data;
  logic       hold;

  assign can_push = !obuf_valid || out_ready;

  // Bits enter at the top and move down, so after eight shifts the earliest
  // bit sits in bit 0. A flush pads with zeros to reach that alignment.
  always_comb begin
    pend_bits_next  = pend_bits;
    pend_cnt_next   = pend_cnt;
    held_next       = held;
    held_valid_next = held_valid;
    push            = 1'b0;
    push_data       = '0;
    hold            = 1'b0;
    if (cmd.shift) begin
      if (pend_cnt == 4'd8) begin
        if (held_valid && !can_push) begin
          hold = 1'b1;
        end else begin
          push            = held_valid;
          push_data       = '{out_byte: held, last: 1'b0};
          held_next       = pend_bits;
          held_valid_next = 1'b1;
          pend_bits_next  = {cmd.bit_val, 7'b0};
          pend_cnt_next   = 4'd1;
        end
      end else begin
        pend_bits_next = {cmd.bit_val, pend_bits[7:1]};
        pend_cnt_next  = pend_cnt + 4'd1;
      end
    end else if (cmd.end_item) begin
      if (held_valid) begin
        if (can_push) begin
          push            = 1'b1;
          push_data       = '{out_byte: held, last: 1'b1};
          held_valid_next = 1'b0;
        end else begin
          hold = 1'b1;
        end
      end
    end else if (cmd.flush) begin
      hold = 1'b1;
      if (pend_cnt != 4'd8) begin
        pend_bits_next = {1'b0, pend_bits[7:1]};
        pend_cnt_next  = pend_cnt + 4'd1;
      end else if (can_push) begin
        hold           = 1'b0;
        push           = 1'b1;
        push_data      = '{out_byte: pend_bits, last: 1'b1};
        pend_bits_next = '0;
        pend_cnt_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_cnt   <= '0;
      held_valid <= 1'b0;
      obuf_valid <= 1'b0;
    end else begin
      pend_bits  <= pend_bits_next;
      pend_cnt   <= pend_cnt_next;
      held_valid <= held_valid_next;
      if (push) begin
        obuf_valid <= 1'b1;
      end else if (out_ready) begin
        obuf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    if (push) begin
      obuf <= push_data;
    end
  end

  assign stat.hold  = hold;
  assign stat.empty = (pend_cnt == 4'd0);
  assign out_valid  = obuf_valid;
  assign out_data   = obuf;

`include "huffman_code_bit_packer_top_macros.svh"

  `HCBP_ASSERT_SAME(a_cnt_range, 1'b1, pend_cnt <= 4'd8, "pending count above eight")
  `HCBP_ASSERT_NEXT(a_flush_empties, cmd.flush && !hold, pend_cnt == 4'd0, "flush left bits")
  `HCBP_ASSERT_NEXT(a_end_drains, cmd.end_item && !hold, !held_valid, "held byte not released")

endmodule

@@ rtl/huffman_code_bit_packer_top.sv @@
// A data beat passes acceptance, one table read, a shift per code bit through the
// code shift register and a closing step, or ends at the read for a zero length.
// Load and unused beats end at acceptance; a flush pads the pending byte with zeros
// one bit per cycle. Results leave through a one-deep output register.
// Reset (rst, synchronous) empties the pending byte and the output register;
// the code table is not cleared and holds nothing valid until loaded.
module huffman_code_bit_packer_top
  import hcbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]         state, state_next;
  logic [CODE_W-1:0]  sreg;
  logic [LEN_W-1:0]   len_m1;
  logic [LEN_W-1:0]   cnt;
  logic               accept;
  logic               sym_ok;
  logic [LEN_W-1:0]   load_len;
  logic [ENTRY_W-1:0] rd_data;
  logic [LEN_W-1:0]   rd_len;
  pk_cmd_t            cmd;
  pk_stat_t           stat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign sym_ok   = ({1'b0, in_data.symbol} < 9'(SYMBOLS));
  assign load_len = (in_data.code_length > LEN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : in_data.code_length;
  assign rd_len   = rd_data[ENTRY_W-1:CODE_W];

  hcbp_table u_table (
    .clk     (clk),
    .wr_en   (accept && in_data.kind == KIND_LOAD && sym_ok),
    .wr_addr (in_data.symbol[SYM_W-1:0]),
    .wr_data ({load_len, in_data.code_word}),
    .rd_en   (accept && in_data.kind == KIND_DATA && sym_ok),
    .rd_addr (in_data.symbol[SYM_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    cmd          = '0;
    cmd.shift    = (state == S_SHIFT);
    cmd.bit_val  = sreg[len_m1];
    cmd.end_item = (state == S_END);
    cmd.flush    = (state == S_FLUSH);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_DATA && sym_ok) begin
            state_next = S_LOOK;
          end else if (in_data.kind == KIND_FLUSH && !stat.empty) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_LOOK: begin
        state_next = (rd_len == '0) ? S_IDLE : S_SHIFT;
      end
      S_SHIFT: begin
        if (!stat.hold && cnt == LEN_W'(1)) begin
          state_next = S_END;
        end
      end
      S_END, S_FLUSH: begin
        if (!stat.hold) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The code leaves most significant bit first: the tap stays fixed at the
  // top of the code while the register moves up one place per bit.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      sreg   <= rd_data[CODE_W-1:0];
      len_m1 <= rd_len - LEN_W'(1);
      cnt    <= rd_len;
    end else if (state == S_SHIFT && !stat.hold) begin
      sreg <= {sreg[CODE_W-2:0], 1'b0};
      cnt  <= cnt - LEN_W'(1);
    end
  end

  hcbp_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`include "huffman_code_bit_packer_top_macros.svh"

  `HCBP_ASSERT_SAME(a_shift_cnt, state == S_SHIFT, cnt != '0, "shifting with no bits left")
  `HCBP_ASSERT_NEXT(a_look_follows, state == S_LOOK, state == S_IDLE || state == S_SHIFT,
                    "bad step after table read")
  `HCBP_ASSERT_SAME(a_idle_ready, state == S_IDLE, !stat.hold, "packer stalled while idle")

endmodule
